FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tar_pkg.sv
// ---------------------------------------------------------------------------
// Triangle axis rotation package
// Widths, pipeline stage indices, axis codes and the arithmetic helpers.
// ---------------------------------------------------------------------------
package tar_pkg;

    // Coordinate format: signed Q16.16 at the default width
    localparam int COORD_WIDTH = 32;
    localparam int PT_N        = 9;
    localparam int VERT_N      = 3;

    // Angle: unsigned fraction of a turn, top bits select the quadrant
    localparam int ANGLE_W = 16;
    localparam int QUAD_W  = 2;

    // CORDIC datapath, scaled to 2^32 per turn and 2^30 unit magnitude
    localparam int CORDIC_W        = 32;
    localparam int CORDIC_RW       = CORDIC_W + 1;
    localparam int Z_SHIFT         = CORDIC_W - ANGLE_W;
    localparam int CORDIC_STEPS    = 30;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int CORDIC_X0       = 652032874;

    // Trig values in Q1.15, one guard bit so a negation always fits
    localparam int TRIG_W   = 17;
    localparam int TRIG_MAX = 32767;
    localparam int TRIG_MIN = -32768;

    // Rounding to nearest, half up, at the Q1.15 product point
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);

    // Product and sum widths
    localparam int PROD_W = COORD_WIDTH + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_CMAX =
        {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_CMIN = ~SUM_CMAX;

    // Pipeline stage indices
    localparam int STG_TRIG = CORDIC_STAGES + 1;
    localparam int STG_MUL  = CORDIC_STAGES + 2;
    localparam int STG_OUT  = CORDIC_STAGES + 3;
    localparam int NSTG     = CORDIC_STAGES + 4;

    // Coordinate positions within a vertex
    localparam int IDX_X = 0;
    localparam int IDX_Y = 1;
    localparam int IDX_Z = 2;

    // Axis selector codes
    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;
    localparam logic [1:0] AXIS_NONE  = 2'd3;

    // Quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]      trig_t;
    typedef logic signed [PROD_W-1:0]      prod_w_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [QUAD_W-1:0] quad;
        coord_t [PT_N-1:0] pt;
    } carry_t;

    typedef struct packed {
        prod_w_t uc;
        prod_w_t vs;
        prod_w_t us;
        prod_w_t vc;
    } prod_t;

    // Arctangent of 2^-i at 2^32 per turn
    function automatic logic signed [CORDIC_W-1:0] atan_val(input int i);
        logic signed [CORDIC_W-1:0] a;
        case (i)
            0:  a = CORDIC_W'(536870912);
            1:  a = CORDIC_W'(316933406);
            2:  a = CORDIC_W'(167458907);
            3:  a = CORDIC_W'(85004756);
            4:  a = CORDIC_W'(42667331);
            5:  a = CORDIC_W'(21354465);
            6:  a = CORDIC_W'(10679838);
            7:  a = CORDIC_W'(5340245);
            8:  a = CORDIC_W'(2670163);
            9:  a = CORDIC_W'(1335087);
            10: a = CORDIC_W'(667544);
            11: a = CORDIC_W'(333772);
            12: a = CORDIC_W'(166886);
            13: a = CORDIC_W'(83443);
            14: a = CORDIC_W'(41722);
            15: a = CORDIC_W'(20861);
            16: a = CORDIC_W'(10430);
            17: a = CORDIC_W'(5215);
            18: a = CORDIC_W'(2608);
            19: a = CORDIC_W'(1304);
            20: a = CORDIC_W'(652);
            21: a = CORDIC_W'(326);
            22: a = CORDIC_W'(163);
            23: a = CORDIC_W'(81);
            24: a = CORDIC_W'(41);
            25: a = CORDIC_W'(20);
            26: a = CORDIC_W'(10);
            27: a = CORDIC_W'(5);
            28: a = CORDIC_W'(3);
            29: a = CORDIC_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // One rotation-mode CORDIC iteration; the shift is fixed per stage
    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        cordic_t r;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (!c.z[CORDIC_W-1])
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - atan_val(i);
        end
        else
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + atan_val(i);
        end
        return r;
    endfunction

    // The iterations held by one pipeline stage
    function automatic cordic_t cordic_stage(input cordic_t c, input int first);
        cordic_t r;
        r = c;
        for (int j = 0; j < STEPS_PER_STAGE; j++)
        begin
            r = cordic_step(r, first + j);
        end
        return r;
    endfunction

    // Round a CORDIC output to Q1.15 and clamp
    function automatic trig_t trig_round(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_RW-1:0] r;
        trig_t t;
        r = CORDIC_RW'(v) + CORDIC_RW'(ROUND_BIAS);
        r = r >>> FRAC_SHIFT;
        if (r > CORDIC_RW'(TRIG_MAX))
            t = TRIG_W'(TRIG_MAX);
        else if (r < CORDIC_RW'(TRIG_MIN))
            t = TRIG_W'(TRIG_MIN);
        else
            t = r[TRIG_W-1:0];
        return t;
    endfunction

    // Round a sum of products to Q16.16 and saturate
    function automatic coord_t round_sat(input sum_t s);
        sum_t   r;
        coord_t c;
        r = s + SUM_W'(ROUND_BIAS);
        r = r >>> FRAC_SHIFT;
        if (r > SUM_CMAX)
            c = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
        else if (r < SUM_CMIN)
            c = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
        else
            c = r[COORD_WIDTH-1:0];
        return c;
    endfunction

endpackage

FILE: rtl/core/triangle_axis_rotate.sv
// ---------------------------------------------------------------------------
// Triangle axis rotation
// Rotates the three vertices of a triangle about the x, y or z axis.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: req_valid / req_stall carry func, turn_angle and the
//   nine Q16.16 vertex coordinates. A request is taken at a rising edge
//   with req_valid high and req_stall low.
//   Result channel: res_valid / res_stall carry the nine rotated, saturated
//   coordinates, one result for every request, in request order.
//   func 0 rolls about x, 1 pitches about y, 2 yaws about z, 3 passes the
//   coordinates through.
//   Throughput: one request per cycle while req_stall is low. The pipeline
//   has 19 register stages: an input register, 15 CORDIC stages of two
//   iterations each, a trig rounding stage, a multiplier stage and the
//   output register; the CORDIC sets the depth.
//   Stall: when res_stall holds a result, earlier stages keep filling any
//   empty slots, so req_stall rises only once every stage holds a request.
//   Reset: all stages empty, res_valid low, requests taken at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_axis_rotate (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [1:0]             func,
    input  logic [15:0]            turn_angle,
    input  tar_pkg::coord_t        a_x,
    input  tar_pkg::coord_t        a_y,
    input  tar_pkg::coord_t        a_z,
    input  tar_pkg::coord_t        b_x,
    input  tar_pkg::coord_t        b_y,
    input  tar_pkg::coord_t        b_z,
    input  tar_pkg::coord_t        c_x,
    input  tar_pkg::coord_t        c_y,
    input  tar_pkg::coord_t        c_z,
    output logic                   res_valid,
    input  logic                   res_stall,
    output tar_pkg::coord_t        ra_x,
    output tar_pkg::coord_t        ra_y,
    output tar_pkg::coord_t        ra_z,
    output tar_pkg::coord_t        rb_x,
    output tar_pkg::coord_t        rb_y,
    output tar_pkg::coord_t        rb_z,
    output tar_pkg::coord_t        rc_x,
    output tar_pkg::coord_t        rc_y,
    output tar_pkg::coord_t        rc_z
);
    import tar_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] vld_in;
    logic [NSTG-1:0] adv;

    carry_t  car_reg [0:CORDIC_STAGES];
    cordic_t cor_reg [0:CORDIC_STAGES];

    carry_t  trig_car_reg;
    trig_t   sin_reg;
    trig_t   cos_reg;
    trig_t   sin_next;
    trig_t   cos_next;
    logic    trig_ok;

    logic [1:0]          mul_func_reg;
    coord_t [PT_N-1:0]   mul_pt_reg;
    prod_t [VERT_N-1:0]  prod_reg;
    prod_t [VERT_N-1:0]  prod_next;

    coord_t [PT_N-1:0]   out_pt_reg;
    coord_t [PT_N-1:0]   out_pt_next;

    carry_t  in_car;
    cordic_t in_cor;

    // Advance a stage when some stage at or after it is empty, or the result is taken
    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_adv
            assign adv[k] = !res_stall || !(&vld_reg[NSTG-1:k]);
        end
    endgenerate

    assign req_stall = !adv[0];
    assign vld_in    = {vld_reg[NSTG-2:0], req_valid};
    assign vld_next  = (adv & vld_in) | (~adv & vld_reg);

    // Move the valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Pack the request and seed the CORDIC
    always_comb
    begin
        in_car.func = func;
        in_car.quad = turn_angle[ANGLE_W-1:ANGLE_W-QUAD_W];
        in_car.pt   = {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x};
        in_cor.x    = CORDIC_W'(CORDIC_X0);
        in_cor.y    = '0;
        in_cor.z    = CORDIC_W'({turn_angle[ANGLE_W-QUAD_W-1:0], {Z_SHIFT{1'b0}}});
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            car_reg[0] <= in_car;
            cor_reg[0] <= in_cor;
        end
    end

    // Run two CORDIC iterations in each stage
    generate
        for (k = 1; k <= CORDIC_STAGES; k++)
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    car_reg[k] <= car_reg[k-1];
                    cor_reg[k] <= cordic_stage(cor_reg[k-1], (k - 1) * STEPS_PER_STAGE);
                end
            end
        end
    endgenerate

    // Round sine and cosine, then fold in the quadrant
    always_comb
    begin
        trig_t s;
        trig_t c;
        s = trig_round(cor_reg[CORDIC_STAGES].y);
        c = trig_round(cor_reg[CORDIC_STAGES].x);
        case (car_reg[CORDIC_STAGES].quad)
            QUAD_0:
            begin
                sin_next = s;
                cos_next = c;
            end
            QUAD_1:
            begin
                sin_next = c;
                cos_next = -s;
            end
            QUAD_2:
            begin
                sin_next = -s;
                cos_next = -c;
            end
            QUAD_3:
            begin
                sin_next = -c;
                cos_next = s;
            end
            default:
            begin
                sin_next = s;
                cos_next = c;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[STG_TRIG])
        begin
            trig_car_reg <= car_reg[CORDIC_STAGES];
            sin_reg      <= sin_next;
            cos_reg      <= cos_next;
        end
    end

    // Pick the coordinate pair for the axis and form the four products
    always_comb
    begin
        coord_t u;
        coord_t v;
        for (int n = 0; n < VERT_N; n++)
        begin
            case (trig_car_reg.func)
                AXIS_ROLL:
                begin
                    u = trig_car_reg.pt[3 * n + IDX_Y];
                    v = trig_car_reg.pt[3 * n + IDX_Z];
                end
                AXIS_PITCH:
                begin
                    u = trig_car_reg.pt[3 * n + IDX_Z];
                    v = trig_car_reg.pt[3 * n + IDX_X];
                end
                default:
                begin
                    u = trig_car_reg.pt[3 * n + IDX_X];
                    v = trig_car_reg.pt[3 * n + IDX_Y];
                end
            endcase
            prod_next[n].uc = PROD_W'(u) * PROD_W'(cos_reg);
            prod_next[n].vs = PROD_W'(v) * PROD_W'(sin_reg);
            prod_next[n].us = PROD_W'(u) * PROD_W'(sin_reg);
            prod_next[n].vc = PROD_W'(v) * PROD_W'(cos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[STG_MUL])
        begin
            mul_func_reg <= trig_car_reg.func;
            mul_pt_reg   <= trig_car_reg.pt;
            prod_reg     <= prod_next;
        end
    end

    // Sum, round, saturate and put the rotated pair back in place
    always_comb
    begin
        coord_t nu;
        coord_t nv;
        out_pt_next = mul_pt_reg;
        for (int n = 0; n < VERT_N; n++)
        begin
            nu = round_sat(SUM_W'(prod_reg[n].uc) - SUM_W'(prod_reg[n].vs));
            nv = round_sat(SUM_W'(prod_reg[n].us) + SUM_W'(prod_reg[n].vc));
            case (mul_func_reg)
                AXIS_ROLL:
                begin
                    out_pt_next[3 * n + IDX_Y] = nu;
                    out_pt_next[3 * n + IDX_Z] = nv;
                end
                AXIS_PITCH:
                begin
                    out_pt_next[3 * n + IDX_Z] = nu;
                    out_pt_next[3 * n + IDX_X] = nv;
                end
                AXIS_YAW:
                begin
                    out_pt_next[3 * n + IDX_X] = nu;
                    out_pt_next[3 * n + IDX_Y] = nv;
                end
                default:
                begin
                    out_pt_next[3 * n + IDX_X] = mul_pt_reg[3 * n + IDX_X];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[STG_OUT])
            out_pt_reg <= out_pt_next;
    end

    // Drive the result channel
    assign res_valid = vld_reg[STG_OUT];
    assign ra_x = out_pt_reg[IDX_X];
    assign ra_y = out_pt_reg[IDX_Y];
    assign ra_z = out_pt_reg[IDX_Z];
    assign rb_x = out_pt_reg[3 + IDX_X];
    assign rb_y = out_pt_reg[3 + IDX_Y];
    assign rb_z = out_pt_reg[3 + IDX_Z];
    assign rc_x = out_pt_reg[6 + IDX_X];
    assign rc_y = out_pt_reg[6 + IDX_Y];
    assign rc_z = out_pt_reg[6 + IDX_Z];

    // Trig values stay within the negatable range
    assign trig_ok = (sin_reg >= -TRIG_MAX) && (sin_reg <= TRIG_MAX)
                  && (cos_reg >= -TRIG_MAX) && (cos_reg <= TRIG_MAX);

    // Checks on the pipeline control and the trig stage
    `ASSERT_NEXT(a_req_lands, clk, rst_n, req_valid && !req_stall, vld_reg[0], "request lost")
    `ASSERT_IMPL(a_full_stall, clk, rst_n, (&vld_reg) && res_stall, req_stall, "taken while full")
    `ASSERT_IMPL(a_trig_range, clk, rst_n, vld_reg[STG_TRIG], trig_ok, "trig value out of range")

endmodule
